[src/jtg_pkg.sv]
`default_nettype none

package jtg_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int MAX_POINTS  = 64;
  localparam int COUNT_WIDTH = 7;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int D2_W    = 2 * IDX_W;
  localparam int D3_W    = 3 * IDX_W;
  localparam int D5_W    = 5 * IDX_W;
  localparam int INNER_W = D2_W + 4;

  // path parameter s is unsigned q1.16
  localparam int FRAC      = 16;
  localparam int S_W       = FRAC + 1;
  localparam int DVD_W     = D5_W + S_W;
  localparam int DIV_CNT_W = $clog2(S_W);
  localparam int PROD_W    = (S_W + 1) + (ANGLE_WIDTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = ((6 * ANGLE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((IDX_W + 3 * ANGLE_WIDTH + 7) / 8) * 8;

  // one classified request, ready for the point generator
  typedef struct packed {
    logic [2:0][ANGLE_WIDTH-1:0] start;
    logic [2:0][ANGLE_WIDTH:0]   diff;
    logic [IDX_W-1:0]            d;
    logic [D2_W-1:0]             d2;
    logic [D5_W-1:0]             den;
    logic                        quintic;
  } jtg_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jtg_qstat_t;

endpackage

`default_nettype wire

[src/joint_trajectory_generator_core.sv]
`default_nettype none

// Joint trajectory generator. Each request on the s side carries start and end
// angles (signed q3.12) for three joints, a point count N (0 taken as 1, above
// 64 taken as 64) and in tuser the time scaling, 0 cubic and 1 quintic. It
// produces N points on the m side, each with its index and the three angles
// start + s*(end - start), tlast on the final point; point 0 is the start pose
// and the final point the end pose exactly when N is above 1. A front stage
// takes a request and queues up to two of them, so new requests are taken while
// points are still being produced. Each point passes through the back stage,
// where a bit-serial divider forms s; the output register lets the next point
// be computed while one waits for tready.
module joint_trajectory_generator_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // start_angle_a, start_angle_b, start_angle_c, end_angle_a, end_angle_b,
  // end_angle_c, point_count
  input  wire logic [jtg_pkg::IN_DATA_W-1:0] s_tdata,
  // scaling_mode
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // point_index, angle_a, angle_b, angle_c
  output logic [jtg_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tlast
);
  import jtg_pkg::*;

  jtg_job_t   push_job;
  jtg_job_t   head_job;
  jtg_qstat_t qstat;
  logic       q_push;
  logic       q_pop;

  jtg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .qstat    (qstat),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  jtg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_job),
    .pop   (q_pop),
    .dout  (head_job),
    .qstat (qstat)
  );

  jtg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .head     (head_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && qstat.full))
    else $error("request queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && qstat.empty))
    else $error("request queue popped while empty");

  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("front took a request while still working on one");

endmodule

`default_nettype wire

[src/jtg_front.sv]
`default_nettype none

module jtg_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [jtg_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                         s_tuser,
  input  wire jtg_pkg::jtg_qstat_t          qstat,
  output logic                              q_push,
  output jtg_pkg::jtg_job_t                 q_job
);
  import jtg_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_POW2, F_POW3, F_POW5, F_PUSH} state_t;

  state_t                 state;
  logic [D3_W-1:0]        d3;
  logic [COUNT_WIDTH-1:0] n_raw;
  logic [COUNT_WIDTH-1:0] n_clamped;
  logic [2:0][ANGLE_WIDTH:0] diff_in;

  assign s_tready = (state == F_IDLE);
  assign q_push   = (state == F_PUSH) && !qstat.full;

  always_comb begin
    n_raw = s_tdata[6*ANGLE_WIDTH +: COUNT_WIDTH];
    if (n_raw == '0) begin
      n_clamped = COUNT_WIDTH'(1);
    end else if (n_raw > COUNT_WIDTH'(MAX_POINTS)) begin
      n_clamped = COUNT_WIDTH'(MAX_POINTS);
    end else begin
      n_clamped = n_raw;
    end
    for (int j = 0; j < 3; j++) begin
      diff_in[j] = {s_tdata[(3+j)*ANGLE_WIDTH + ANGLE_WIDTH - 1],
                    s_tdata[(3+j)*ANGLE_WIDTH +: ANGLE_WIDTH]}
                 - {s_tdata[j*ANGLE_WIDTH + ANGLE_WIDTH - 1],
                    s_tdata[j*ANGLE_WIDTH +: ANGLE_WIDTH]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            for (int j = 0; j < 3; j++) begin
              q_job.start[j] <= s_tdata[j*ANGLE_WIDTH +: ANGLE_WIDTH];
            end
            q_job.diff    <= diff_in;
            q_job.d       <= IDX_W'(n_clamped - COUNT_WIDTH'(1));
            q_job.quintic <= s_tuser;
            state         <= F_POW2;
          end
        end
        F_POW2: begin
          q_job.d2 <= D2_W'(q_job.d) * D2_W'(q_job.d);
          state    <= F_POW3;
        end
        F_POW3: begin
          d3    <= D3_W'(q_job.d2) * D3_W'(q_job.d);
          state <= F_POW5;
        end
        F_POW5: begin
          // cubic divides by d^3, quintic by d^5
          q_job.den <= q_job.quintic ? D5_W'(D5_W'(d3) * D5_W'(q_job.d2)) : D5_W'(d3);
          state     <= F_PUSH;
        end
        F_PUSH: begin
          if (!qstat.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/jtg_queue.sv]
`default_nettype none

module jtg_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire jtg_pkg::jtg_job_t  din,
  input  wire logic               pop,
  output jtg_pkg::jtg_job_t       dout,
  output jtg_pkg::jtg_qstat_t     qstat
);
  import jtg_pkg::*;

  jtg_job_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign dout        = entries[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/jtg_back.sv]
`default_nettype none

module jtg_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire jtg_pkg::jtg_qstat_t           qstat,
  input  wire jtg_pkg::jtg_job_t             head,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [jtg_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tlast
);
  import jtg_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_PROD1, B_PROD2, B_PROD3, B_LOAD, B_DIV, B_MUL, B_EMIT
  } state_t;

  state_t                 state;
  logic [IDX_W-1:0]       idx;
  logic [D2_W-1:0]        i2;
  logic [D2_W-1:0]        id;
  logic [D3_W-1:0]        i3;
  logic [D3_W-1:0]        i2d;
  logic [INNER_W-1:0]     inner;
  logic [D5_W-1:0]        num;
  logic [D5_W-1:0]        rem;
  logic [S_W-1:0]         quo;
  logic [DIV_CNT_W-1:0]   cnt;
  logic signed [PROD_W-1:0] prod [3];

  logic [D3_W+1:0]        num_cubic;
  logic [D5_W+3:0]        num_quintic;
  logic [DVD_W-1:0]       dividend;
  logic [D5_W:0]          div_cat;
  logic [D5_W+1:0]        div_trial;
  logic [S_W-1:0]         s_val;
  logic signed [PROD_W-1:0] rnd_sum [3];
  logic signed [PROD_W-1:0] rnd_sh  [3];
  logic [2:0][ANGLE_WIDTH-1:0] angle;
  logic                   load_ok;
  logic                   last;

  always_comb begin
    num_cubic   = (D3_W+2)'(3) * (D3_W+2)'(i2d) - (D3_W+2)'(2) * (D3_W+2)'(i3);
    num_quintic = (D5_W+4)'(i3) * (D5_W+4)'(inner);
    // round to nearest: add half the divisor before dividing
    dividend    = DVD_W'({num, FRAC'(0)}) + DVD_W'(head.den >> 1);
    div_cat     = {rem, quo[S_W-1]};
    div_trial   = {1'b0, div_cat} - (D5_W+2)'(head.den);
    s_val       = (head.d == '0) ? '0 : quo;
    for (int j = 0; j < 3; j++) begin
      rnd_sum[j] = prod[j] + $signed(PROD_W'(1 << (FRAC - 1)));
      rnd_sh[j]  = rnd_sum[j] >>> FRAC;
      angle[j]   = head.start[j] + rnd_sh[j][ANGLE_WIDTH-1:0];
    end
    load_ok = !m_tvalid || m_tready;
    last    = (idx == head.d);
  end

  assign q_pop = (state == B_EMIT) && load_ok && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == B_EMIT && load_ok) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!qstat.empty) begin
            idx   <= '0;
            state <= B_PROD1;
          end
        end
        B_PROD1: begin
          i2    <= D2_W'(idx) * D2_W'(idx);
          id    <= D2_W'(idx) * D2_W'(head.d);
          state <= B_PROD2;
        end
        B_PROD2: begin
          i3    <= D3_W'(i2) * D3_W'(idx);
          i2d   <= D3_W'(i2) * D3_W'(head.d);
          // 10d^2 - 15id + 6i^2 is never negative for any i, d
          inner <= INNER_W'(10) * INNER_W'(head.d2) + INNER_W'(6) * INNER_W'(i2)
                 - INNER_W'(15) * INNER_W'(id);
          state <= B_PROD3;
        end
        B_PROD3: begin
          num   <= head.quintic ? num_quintic[D5_W-1:0] : D5_W'(num_cubic);
          state <= B_LOAD;
        end
        B_LOAD: begin
          // quotient fits s bits, so the top part is already below the divisor
          rem   <= dividend[DVD_W-1:S_W];
          quo   <= dividend[S_W-1:0];
          cnt   <= DIV_CNT_W'(S_W - 1);
          state <= B_DIV;
        end
        B_DIV: begin
          if (!div_trial[D5_W+1]) begin
            rem <= div_trial[D5_W-1:0];
            quo <= {quo[S_W-2:0], 1'b1};
          end else begin
            rem <= div_cat[D5_W-1:0];
            quo <= {quo[S_W-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= B_MUL;
          end else begin
            cnt <= cnt - DIV_CNT_W'(1);
          end
        end
        B_MUL: begin
          for (int j = 0; j < 3; j++) begin
            prod[j] <= $signed({1'b0, s_val}) * $signed(head.diff[j]);
          end
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (load_ok) begin
            m_tdata  <= OUT_DATA_W'({angle[2], angle[1], angle[0], idx});
            m_tlast  <= last;
            if (last) begin
              state <= B_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= B_PROD1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import jtg_pkg::*;

  localparam logic MODE_CUBIC   = 1'b0;
  localparam logic MODE_QUINTIC = 1'b1;
  localparam int   PAD_W        = IN_DATA_W - 6 * ANGLE_WIDTH - COUNT_WIDTH;

  typedef struct packed {
    logic                   mode;
    logic [COUNT_WIDTH-1:0] count;
    logic [ANGLE_WIDTH-1:0] end_c;
    logic [ANGLE_WIDTH-1:0] end_b;
    logic [ANGLE_WIDTH-1:0] end_a;
    logic [ANGLE_WIDTH-1:0] start_c;
    logic [ANGLE_WIDTH-1:0] start_b;
    logic [ANGLE_WIDTH-1:0] start_a;
  } motion_req_t;

  typedef struct packed {
    logic                   last;
    logic [ANGLE_WIDTH-1:0] ang_c;
    logic [ANGLE_WIDTH-1:0] ang_b;
    logic [ANGLE_WIDTH-1:0] ang_a;
    logic [IDX_W-1:0]       index;
  } traj_point_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  motion_req_t pending_requests[$];
  traj_point_t expected_points[$];
  motion_req_t active_req;
  bit          req_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  joint_trajectory_generator_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // s in unsigned q1.16, exact ratio rounded to nearest
  function automatic longint unsigned path_fraction(int unsigned i, int unsigned d,
                                                    logic quintic);
    longint unsigned li, ld, num, den;
    li = i;
    ld = d;
    if (quintic == MODE_QUINTIC) begin
      num = li * li * li * (10 * ld * ld + 6 * li * li - 15 * li * ld);
      den = ld * ld * ld * ld * ld;
    end else begin
      num = 3 * li * li * ld - 2 * li * li * li;
      den = ld * ld * ld;
    end
    return (num * 65536 + den / 2) / den;
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] blend_angle(logic [ANGLE_WIDTH-1:0] a_raw,
                                                         logic [ANGLE_WIDTH-1:0] b_raw,
                                                         longint unsigned s16);
    longint a, b, acc;
    a = longint'($signed(a_raw));
    b = longint'($signed(b_raw));
    acc = a * 65536 + longint'(s16) * (b - a) + 32768;
    return ANGLE_WIDTH'(acc >>> 16);
  endfunction

  function automatic void plan_trajectory(motion_req_t r);
    int unsigned     n, d;
    longint unsigned s16;
    traj_point_t     p;
    n = r.count;
    if (n == 0) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    d = n - 1;
    for (int unsigned i = 0; i < n; i++) begin
      s16 = (d == 0) ? 0 : path_fraction(i, d, r.mode);
      p.index = IDX_W'(i);
      p.ang_a = blend_angle(r.start_a, r.end_a, s16);
      p.ang_b = blend_angle(r.start_b, r.end_b, s16);
      p.ang_c = blend_angle(r.start_c, r.end_c, s16);
      p.last  = (i == d);
      expected_points.insert(expected_points.size(), p);
    end
  endfunction

  // driver: one request held on the slave side until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || req_taken) begin
        req_taken = 1'b0;
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          active_req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{PAD_W{1'b0}}, active_req.count,
                       active_req.end_c, active_req.end_b, active_req.end_a,
                       active_req.start_c, active_req.start_b, active_req.start_a};
          s_tuser  <= active_req.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: requests taken and points delivered
  always @(posedge clk) begin
    traj_point_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req_taken = 1'b1;
        plan_trajectory(active_req);
      end
      if (m_tvalid && m_tready) begin
        got.index = m_tdata[IDX_W-1:0];
        got.ang_a = m_tdata[IDX_W +: ANGLE_WIDTH];
        got.ang_b = m_tdata[IDX_W + ANGLE_WIDTH +: ANGLE_WIDTH];
        got.ang_c = m_tdata[IDX_W + 2 * ANGLE_WIDTH +: ANGLE_WIDTH];
        got.last  = m_tlast;
        if (expected_points.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected point idx %0d a %0d b %0d c %0d last %0b", got.index,
                     $signed(got.ang_a), $signed(got.ang_b), $signed(got.ang_c), got.last);
        end else begin
          want = expected_points.pop_front();
          if (got.index !== want.index || got.ang_a !== want.ang_a ||
              got.ang_b !== want.ang_b || got.ang_c !== want.ang_c ||
              got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("point mismatch: exp idx %0d a %0d b %0d c %0d last %0b,",
                       want.index, $signed(want.ang_a), $signed(want.ang_b),
                       $signed(want.ang_c), want.last,
                       " got idx %0d a %0d b %0d c %0d last %0b",
                       got.index, $signed(got.ang_a), $signed(got.ang_b),
                       $signed(got.ang_c), got.last);
          end
        end
      end
    end
  end

  task automatic queue_request(logic [ANGLE_WIDTH-1:0] sa, logic [ANGLE_WIDTH-1:0] sb,
                               logic [ANGLE_WIDTH-1:0] sc, logic [ANGLE_WIDTH-1:0] ea,
                               logic [ANGLE_WIDTH-1:0] eb, logic [ANGLE_WIDTH-1:0] ec,
                               int unsigned count, logic mode);
    motion_req_t r;
    r.start_a = sa;
    r.start_b = sb;
    r.start_c = sc;
    r.end_a   = ea;
    r.end_b   = eb;
    r.end_c   = ec;
    r.count   = COUNT_WIDTH'(count);
    r.mode    = mode;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      1: return {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      2: return '0;
      default: return ANGLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] pick_end(logic [ANGLE_WIDTH-1:0] st);
    // short moves now and then, where rounding matters most
    if ($urandom_range(0, 3) == 0)
      return st + ANGLE_WIDTH'($urandom_range(0, 64)) - ANGLE_WIDTH'(32);
    return pick_angle();
  endfunction

  function automatic int unsigned pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 12);
    if (sel < 90) return $urandom_range(13, 40);
    if (sel < 97) return $urandom_range(41, MAX_POINTS);
    if (sel == 97) return 0;
    return $urandom_range(MAX_POINTS + 1, (1 << COUNT_WIDTH) - 1);
  endfunction

  task automatic queue_random_requests(int unsigned num);
    logic [ANGLE_WIDTH-1:0] sa, sb, sc;
    for (int unsigned k = 0; k < num; k++) begin
      sa = pick_angle();
      sb = pick_angle();
      sc = pick_angle();
      queue_request(sa, sb, sc, pick_end(sa), pick_end(sb), pick_end(sc), pick_count(),
                    logic'($urandom_range(0, 1)));
    end
  endtask

  // checked at the rising edge, where the driver's outputs are settled
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || s_tvalid || expected_points.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [ANGLE_WIDTH-1:0] amin, amax;
    amin = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
    amax = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: single point, zero count, full swings, saturated counts
    queue_request(amin, amax, 16'h1234, amax, amin, 16'h4321, 1, MODE_CUBIC);
    queue_request(16'h0abc, amin, amax, 16'h7000, amax, amin, 0, MODE_QUINTIC);
    queue_request(amin, amin, amax, amax, amax, amin, 2, MODE_CUBIC);
    queue_request(amax, amin, 16'h0000, amin, amax, 16'hffff, 2, MODE_QUINTIC);
    queue_request(amin, amax, 16'h0000, amax, amin, 16'h0001, 64, MODE_CUBIC);
    queue_request(amax, amin, 16'h0001, amin, amax, 16'h0000, 64, MODE_QUINTIC);
    queue_request(16'h1000, 16'hf000, 16'h0800, 16'h2000, 16'he000, 16'h0400, 65,
                  MODE_CUBIC);
    queue_request(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 127,
                  MODE_QUINTIC);
    queue_request('0, '0, '0, '0, '0, '0, 0, MODE_CUBIC);
    queue_request(16'h5555, 16'haaaa, 16'h00ff, 16'h5555, 16'haaaa, 16'h00ff, 5,
                  MODE_QUINTIC);
    queue_request(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hffff, 16'h0002, 3,
                  MODE_CUBIC);
    queue_request(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hffff, 16'h0003, 4,
                  MODE_QUINTIC);
    queue_request(16'h3243, 16'hcdbd, 16'h6487, 16'hcdbd, 16'h3243, 16'h9b79, 7,
                  MODE_CUBIC);
    queue_request(16'h3243, 16'hcdbd, 16'h6487, 16'hcdbd, 16'h3243, 16'h9b79, 7,
                  MODE_QUINTIC);
    queue_request(amin, amax, amin, amax, amin, amax, 100, MODE_QUINTIC);
    queue_request(16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0020, 11,
                  MODE_CUBIC);
    wait_for_drain();

    // random phases: free running, sender gaps, receiver stalls, both
    queue_random_requests(76);
    wait_for_drain();
    send_idle_pct = 75;
    queue_random_requests(76);
    wait_for_drain();
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    queue_random_requests(76);
    wait_for_drain();
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    queue_random_requests(76);
    wait_for_drain();

    recv_stall_pct = 0;
    repeat (200) @(negedge clk);
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[joint_trajectory_generator_core.f]
src/jtg_pkg.sv
src/jtg_front.sv
src/jtg_queue.sv
src/jtg_back.sv
src/joint_trajectory_generator_core.sv
tb/tb.sv
